@@ sv/blms_pkg.sv @@
`default_nettype none

package blms_pkg;

  // Longest window the history register can hold
  localparam int MAX_WINDOW = 31;
  localparam int HIST_W     = MAX_WINDOW;
  localparam int HALF_MAX   = (MAX_WINDOW - 1) / 2;
  localparam int HALF_W     = $clog2(HALF_MAX + 1);
  // Positions, lags, counts and popcounts all fit in this width
  localparam int POS_W      = $clog2(MAX_WINDOW + 1);
  localparam int SEEN_MAX   = MAX_WINDOW - 1;
  localparam int WSIZE_W    = 5;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(5);

  // Job queue between front and back
  localparam int JQ_DEPTH = 4;
  localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
  localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

  // Result queue on the output side
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // One batch of results caused by one accepted pixel
  typedef struct packed {
    logic [HIST_W-1:0] bits;      // history snapshot, newest in bit 0
    logic [POS_W-1:0]  avail_m1;  // highest valid history position
    logic [HALF_W-1:0] half;      // half window width
    logic [POS_W-1:0]  first_lag; // lag of the oldest owed pixel
    logic [POS_W-1:0]  count;     // number of results to emit
    logic              last;      // batch closes the line
  } job_t;

  typedef struct packed {
    logic smoothed_bit;
    logic line_done;
  } result_t;

endpackage

`default_nettype wire

@@ sv/blms_front.sv @@
`default_nettype none

module blms_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        accept,
  input  wire                        pixel_bit,
  input  wire                        line_end,
  input  wire [blms_pkg::WSIZE_W-1:0] win_len,
  output logic                       job_push,
  output blms_pkg::job_t             job
);
  import blms_pkg::*;

  logic [HIST_W-1:0] recent_r, recent_nxt;
  logic [POS_W-1:0]  seen_r, seen_nxt;
  logic [POS_W-1:0]  pending_r, pending_nxt;
  logic [HALF_W-1:0] half_raw, half;
  logic [POS_W-1:0]  pend_inc;
  logic [POS_W-1:0]  n_out;

  // Half width, limited to what the history can serve
  assign half_raw = win_len[WSIZE_W-1:1];
  assign half     = (half_raw > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : half_raw;

  assign pend_inc = POS_W'(pending_r + 1'b1);

  // Classify the pixel: how many owed results it releases
  always_comb begin
    recent_nxt  = {recent_r[HIST_W-2:0], pixel_bit};
    seen_nxt    = (seen_r == POS_W'(SEEN_MAX)) ? seen_r : POS_W'(seen_r + 1'b1);
    pending_nxt = pend_inc;
    n_out       = '0;
    if (line_end) begin
      n_out       = pend_inc;
      recent_nxt  = '0;
      seen_nxt    = '0;
      pending_nxt = '0;
    end else if (pend_inc > POS_W'(half)) begin
      n_out       = POS_W'(pend_inc - POS_W'(half));
      pending_nxt = POS_W'(half);
    end
  end

  assign job_push      = accept && (n_out != '0);
  assign job.bits      = {recent_r[HIST_W-2:0], pixel_bit};
  assign job.avail_m1  = seen_r;
  assign job.half      = half;
  assign job.first_lag = pending_r;
  assign job.count     = n_out;
  assign job.last      = line_end;

  // Line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r  <= '0;
      seen_r    <= '0;
      pending_r <= '0;
    end else if (accept) begin
      recent_r  <= recent_nxt;
      seen_r    <= seen_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/blms_job_queue.sv @@
`default_nettype none

module blms_job_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  blms_pkg::job_t push_job,
  input  wire            pop,
  output logic           full,
  output logic           valid,
  output blms_pkg::job_t head
);
  import blms_pkg::*;

  job_t                mem_r [JQ_DEPTH];
  logic [JQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == JQ_CNT_W'(JQ_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = JQ_CNT_W'(cnt_r + 1'b1);
    else if (!push && pop) cnt_nxt = JQ_CNT_W'(cnt_r - 1'b1);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= JQ_PTR_W'(wr_ptr_r + 1'b1);
      if (pop)  rd_ptr_r <= JQ_PTR_W'(rd_ptr_r + 1'b1);
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

@@ sv/blms_back.sv @@
`default_nettype none

module blms_back (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            job_valid,
  input  blms_pkg::job_t job,
  output logic           job_pop,
  input  wire            out_pop,
  output logic           out_empty,
  output logic           out_smoothed_bit,
  output logic           out_line_done
);
  import blms_pkg::*;

  logic [POS_W-1:0]    k_r;
  logic [POS_W-1:0]    lag, hi, hi_c, cnt, ones;
  logic [HIST_W-1:0]   masked;
  logic                maj, done, last_step, step, out_room, out_take;
  result_t             oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] owr_r, ord_r;
  logic [OQ_CNT_W-1:0] ocnt_r;

  // Window reach for the current owed pixel, clipped to the history held
  assign lag  = POS_W'(job.first_lag - k_r);
  assign hi   = POS_W'(lag + POS_W'(job.half));
  assign hi_c = (hi > job.avail_m1) ? job.avail_m1 : hi;
  assign cnt  = POS_W'(hi_c + 1'b1);

  // Popcount over the in-range history bits
  always_comb begin
    masked = '0;
    ones   = '0;
    for (int i = 0; i < HIST_W; i++) begin
      masked[i] = job.bits[i] && (POS_W'(i) <= hi_c);
      ones      = POS_W'(ones + POS_W'(masked[i]));
    end
  end

  // Ties count as ones
  assign maj  = ({ones, 1'b0} >= {1'b0, cnt});
  assign done = job.last && (lag == '0);

  // Step through the batch, one result per cycle while there is room
  assign out_take  = out_pop && !out_empty;
  assign out_room  = (ocnt_r != OQ_CNT_W'(OQ_DEPTH)) || out_take;
  assign step      = job_valid && out_room;
  assign last_step = (k_r == POS_W'(job.count - 1'b1));
  assign job_pop   = step && last_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (step) begin
      k_r <= last_step ? '0 : POS_W'(k_r + 1'b1);
    end
  end

  // Result queue
  assign out_empty        = (ocnt_r == '0);
  assign out_smoothed_bit = oq_r[ord_r].smoothed_bit;
  assign out_line_done    = oq_r[ord_r].line_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (step)     owr_r <= OQ_PTR_W'(owr_r + 1'b1);
      if (out_take) ord_r <= OQ_PTR_W'(ord_r + 1'b1);
      if (step && !out_take) ocnt_r <= OQ_CNT_W'(ocnt_r + 1'b1);
      else if (!step && out_take) ocnt_r <= OQ_CNT_W'(ocnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      oq_r[owr_r].smoothed_bit <= maj;
      oq_r[owr_r].line_done    <= done;
    end
  end

endmodule

`default_nettype wire

@@ sv/binary_line_majority_smoother_core.sv @@
`default_nettype none
// Results pass through the job queue and then the result queue. Throughput:
// one pixel per cycle in while in_full is low, one result per cycle out
// unless the result queue is full; a line end releases up to 16 results,
// emitted one per cycle by the single majority unit; the four-entry job queue
// absorbs pixels that arrive during such a burst. Reset: synchronous, active
// low; clears the line state and both queues and sets the window length to 5.

module binary_line_majority_smoother_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire [blms_pkg::WSIZE_W-1:0] cfg_wdata,
  input  wire                         in_push,
  output logic                        in_full,
  input  wire                         in_pixel_bit,
  input  wire                         in_line_end,
  output logic                        out_empty,
  input  wire                         out_pop,
  output logic                        out_smoothed_bit,
  output logic                        out_line_done
);
  import blms_pkg::*;

  logic [WSIZE_W-1:0] win_len_r;
  logic               accept, job_push, job_pop, q_full, q_valid;
  job_t               job_in, job_head;

  // Window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WSIZE_RESET;
    end else if (cfg_we) begin
      win_len_r <= cfg_wdata;
    end
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  blms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .pixel_bit (in_pixel_bit),
    .line_end  (in_line_end),
    .win_len   (win_len_r),
    .job_push  (job_push),
    .job       (job_in)
  );

  blms_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .pop      (job_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (job_head)
  );

  blms_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_valid),
    .job              (job_head),
    .job_pop          (job_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_smoothed_bit (out_smoothed_bit),
    .out_line_done    (out_line_done)
  );

  // A line end always schedules the flush batch
  a_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_line_end) |-> job_push)
    else $error("line end accepted without flush batch");

  // Batches are never empty
  a_job_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (job_in.count != '0))
    else $error("empty batch queued");

  // Queue pops only with a batch present
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> q_valid)
    else $error("batch pop from empty queue");

  // Coming out of reset both sides are clear
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (out_empty && !in_full))
    else $error("queues not clear after reset");

endmodule

`default_nettype wire
